FILE: hdl/slsd_pkg.sv
// slsd_pkg: shared types and codes for the static list symmetric difference core.
// No dependencies; imported by slsd_if, slsd_step and the core.
`timescale 1ns / 1ps
`default_nettype none

package slsd_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_LOAD   = 2'd1,
    FN_TOGGLE = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_ELEMENT  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_LINK,
    S_FREE,
    S_READ,
    S_EMIT
  } state_t;

  typedef logic [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

FILE: hdl/slsd_if.sv
// slsd_if: valid/ready channel interfaces for command input and result output.
// Depends on slsd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface slsd_in_if
  import slsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface slsd_out_if
  import slsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  value_res;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/slsd_ram.sv
// slsd_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module slsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/slsd_step.sv
// slsd_step: shared list step unit; resolves a node's effective link and
// compares its value against the search key. Depends on slsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slsd_step
  import slsd_pkg::*;
#(
  parameter int unsigned NODES = 32
) (
  input  wire logic [$clog2(NODES)-1:0] node,      // node the read data belongs to
  input  wire logic                     link_ok,   // link entry written since clear
  input  wire logic [$clog2(NODES)-1:0] link_rd,
  input  wire val_t                     value_rd,
  input  wire val_t                     key,
  output      logic [$clog2(NODES)-1:0] link_nxt,
  output      logic                     hit
);

  localparam int unsigned AW = $clog2(NODES);

  always_comb begin
    if (link_ok) begin
      // out-of-range links end the chain
      link_nxt = ({1'b0, link_rd} < (AW+1)'(NODES)) ? link_rd : '0;
    end else begin
      // untouched entry: rebuilt free chain, each node to the next
      link_nxt = (node == AW'(NODES-1)) ? '0 : node + AW'(1);
    end
  end

  assign hit = (value_rd == key);

endmodule

`default_nettype wire

FILE: hdl/static_list_symmetric_difference_core.sv
// static_list_symmetric_difference_core: set kept as a linked list in a node pool.
// Depends on slsd_pkg, slsd_if (channels), slsd_ram and slsd_step.
//
// Usage
//   in_ch  : command transactions {func, value}; clear, load (append), toggle
//            membership, read out. in_ch.ready is high only while idle; one
//            command is worked on at a time.
//   out_ch : result transactions {value_res, status, last}. Clear, load and
//            toggle give one result; read-out gives one result per element
//            (or one "list empty" result), last marks the final one.
// Sequence (states from acceptance to the result entering the output register)
//   clear                 : EMIT
//   load                  : ALLOC, LINK, EMIT (pool full: EMIT)
//   toggle, value found   : WALK to the value, FREE, EMIT
//   toggle, value absent  : WALK, ALLOC, LINK, EMIT (pool full: WALK, EMIT)
//   read-out              : READ, one element per cycle
//   Walks take one list node per cycle via the RAM read port and step unit;
//   the next command can be accepted in the cycle after the final result is loaded.
// Stall: the output register holds a result until taken; read-out pauses its
//   walk while out_ch.ready is low. A new command can be accepted while the
//   last result of the previous one still waits.
// Reset (rst_n low, synchronous): empty list, full free chain; node values
//   stay undefined until written. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module static_list_symmetric_difference_core
  import slsd_pkg::*;
#(
  parameter int unsigned NODES = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  slsd_in_if.sink    in_ch,
  slsd_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(NODES);
  typedef logic [AW-1:0] idx_t;

  // control and list registers
  state_t  state_r, state_nxt;
  idx_t    free_head_r, free_head_nxt;
  idx_t    first_r, first_nxt;
  idx_t    last_r, last_nxt;
  idx_t    q_r, q_nxt;            // node under the walk
  idx_t    prev_r, prev_nxt;      // predecessor of q
  idx_t    steps_r, steps_nxt;    // walk length so far
  idx_t    rd_addr_r;             // node whose RAM data is on rdata
  logic [NODES-1:0] lvalid_r;     // link entry written since last clear
  val_t    val_r, val_nxt;
  status_t res_r, res_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  val_t    out_value_r, out_value_nxt;
  status_t out_status_r, out_status_nxt;
  logic    out_last_r, out_last_nxt;

  // RAM and step-unit signals
  idx_t    rd_addr;
  logic    lw_en;
  idx_t    lw_addr;
  idx_t    lw_data;
  logic    vw_en;
  logic    clr_valid;
  idx_t    link_rd;
  val_t    value_rd;
  idx_t    link_nxt;
  logic    hit;

  logic    acc;
  logic    out_load;
  logic    walk_end;
  logic    rd_last;
  func_t   in_func;

  assign in_func  = func_t'(in_ch.func);
  assign in_ch.ready = (state_r == S_IDLE);
  assign acc      = in_ch.valid && in_ch.ready;
  assign out_load = !out_valid_r || out_ch.ready;
  assign walk_end = (q_r == '0) || (steps_r == AW'(NODES-1));
  assign rd_last  = (link_nxt == '0) || (steps_r == AW'(NODES-2));

  // node storage
  slsd_ram #(.WIDTH(AW), .DEPTH(NODES)) u_links (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  slsd_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_values (
    .clk   (clk),
    .we    (vw_en),
    .waddr (free_head_r),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (value_rd)
  );

  slsd_step #(.NODES(NODES)) u_step (
    .node     (rd_addr_r),
    .link_ok  (lvalid_r[rd_addr_r]),
    .link_rd  (link_rd),
    .value_rd (value_rd),
    .key      (val_r),
    .link_nxt (link_nxt),
    .hit      (hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_func)
            FN_CLEAR:  state_nxt = S_EMIT;
            FN_LOAD:   state_nxt = (free_head_r == '0) ? S_EMIT : S_ALLOC;
            FN_TOGGLE: state_nxt = S_WALK;
            FN_READ:   state_nxt = (first_r == '0) ? S_EMIT : S_READ;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_nxt = (free_head_r == '0) ? S_EMIT : S_ALLOC;
        end else if (hit) begin
          state_nxt = S_FREE;
        end
      end
      S_ALLOC: state_nxt = S_LINK;
      S_LINK:  state_nxt = S_EMIT;
      S_FREE:  state_nxt = S_EMIT;
      S_READ: begin
        if (out_load && rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    free_head_nxt = free_head_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    q_nxt         = q_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    rd_addr       = q_r;
    lw_en         = 1'b0;
    lw_addr       = q_r;
    lw_data       = '0;
    vw_en         = 1'b0;
    clr_valid     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          val_nxt   = in_ch.value;
          q_nxt     = first_r;
          prev_nxt  = '0;
          steps_nxt = '0;
          case (in_func)
            FN_CLEAR: begin
              clr_valid     = 1'b1;
              free_head_nxt = AW'(1);
              first_nxt     = '0;
              last_nxt      = '0;
              res_nxt       = ST_CLEARED;
            end
            FN_LOAD: begin
              rd_addr = free_head_r;
              res_nxt = ST_FULL;
            end
            FN_TOGGLE: rd_addr = first_r;
            FN_READ: begin
              rd_addr = first_r;
              res_nxt = ST_EMPTY;
            end
            default: rd_addr = q_r;
          endcase
        end
      end
      S_WALK: begin
        if (walk_end) begin
          rd_addr = free_head_r;
          res_nxt = ST_FULL;
        end else if (hit) begin
          // unlink q
          if (prev_r == '0) begin
            first_nxt = link_nxt;
          end else begin
            lw_en   = 1'b1;
            lw_addr = prev_r;
            lw_data = link_nxt;
          end
          if (q_r == last_r) begin
            last_nxt = prev_r;
          end
        end else begin
          prev_nxt  = q_r;
          q_nxt     = link_nxt;
          steps_nxt = steps_r + AW'(1);
          rd_addr   = link_nxt;
        end
      end
      S_ALLOC: begin
        // take the free head as the new tail node
        q_nxt         = free_head_r;
        free_head_nxt = link_nxt;
        lw_en         = 1'b1;
        lw_addr       = free_head_r;
        lw_data       = '0;
        vw_en         = 1'b1;
      end
      S_LINK: begin
        if (first_r == '0) begin
          first_nxt = q_r;
        end else begin
          lw_en   = 1'b1;
          lw_addr = last_r;
          lw_data = q_r;
        end
        last_nxt = q_r;
        res_nxt  = ST_APPENDED;
      end
      S_FREE: begin
        lw_en         = 1'b1;
        lw_addr       = q_r;
        lw_data       = free_head_r;
        free_head_nxt = q_r;
        res_nxt       = ST_REMOVED;
      end
      S_READ: begin
        if (out_load) begin
          q_nxt     = link_nxt;
          steps_nxt = steps_r + AW'(1);
          rd_addr   = link_nxt;
        end
      end
      default: rd_addr = q_r;
    endcase
  end

  // output register
  always_comb begin
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    if (out_load && state_r == S_EMIT) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = val_r;
      out_status_nxt = res_r;
      out_last_nxt   = 1'b1;
    end else if (out_load && state_r == S_READ) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = value_rd;
      out_status_nxt = ST_ELEMENT;
      out_last_nxt   = rd_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= AW'(1);
      first_r     <= '0;
      last_r      <= '0;
      lvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_valid) begin
        lvalid_r <= '0;
      end else if (lw_en) begin
        lvalid_r[lw_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    rd_addr_r    <= rd_addr;
    val_r        <= val_nxt;
    res_r        <= res_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // head and tail are empty together
  a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (first_r == '0) == (last_r == '0))
    else $error("list head and tail disagree on emptiness");

  // the tail node is never the free head
  a_tail_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    (last_r != '0) |-> (free_head_r != last_r))
    else $error("tail node is also the free head");

  // read-out only ever sits on a real node
  a_read_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (q_r != '0 && rd_addr_r == q_r))
    else $error("read-out walk on node 0 or stale read data");

  // an accepted command always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted command did not start");

endmodule

`default_nettype wire
